>>> rtl/core/ncr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncr_pkg
// Shared types and constants for the numeric character reference decoder.
// ----------------------------------------------------------------------------
package ncr_pkg;

	localparam int VALUE_WIDTH_DEF = 31;
	localparam int CMD_DEPTH       = 2;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_AMP,
		MODE_HASH,
		MODE_DEC,
		MODE_HEX
	} scan_mode_t;

	typedef enum logic [1:0] {
		REF_NONE,
		REF_UTF8,
		REF_KEEP_DEC,
		REF_KEEP_HEX
	} ref_form_t;

	typedef enum logic [0:0] {
		CFG_KEEP_BUILTIN = 1'b0,
		CFG_ESCAPE_AMP   = 1'b1
	} cfg_reg_t;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_X    = 8'h78;

	localparam logic [2:0] AMP_LEN_PLAIN = 3'd1;
	localparam logic [2:0] AMP_LEN_ESC   = 3'd5;
	localparam logic [2:0] KEEP_DEC_LEN  = 3'd5;
	localparam logic [2:0] KEEP_HEX_LEN  = 3'd6;

	typedef struct packed {
		logic keep_builtin;
		logic escape_amp;
	} cfg_t;

	// one expansion job: '&' prefix, then reference bytes, then a literal byte
	typedef struct packed {
		logic [2:0] amp_len;
		ref_form_t  ref_form;
		logic [2:0] ref_len;
		logic       has_plain;
		logic [7:0] plain_byte;
	} cmd_t;

endpackage

>>> rtl/core/numeric_char_reference_to_utf8_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_char_reference_to_utf8_core
// Streaming decoder of decimal and hex character references into UTF-8.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle and emits one output byte per cycle while
// neither the job queue is full nor the output stalled. A beat that
// produces n output bytes (n from 0 to 7) keeps the single output register
// busy until all n are out, so unstalled plain text runs at one beat per
// cycle. The scanner feeds a two-entry job queue; input stalls only while
// that queue is full. Bytes pass the job queue, then the output register.
// ----------------------------------------------------------------------------
module numeric_char_reference_to_utf8_core import ncr_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last
);

	localparam int JOB_W = $bits(cmd_t) + VALUE_WIDTH;

	cfg_t                   cfg_q;
	logic                   fifo_full, push, pop, head_valid;
	cmd_t                   push_cmd, head_cmd;
	logic [VALUE_WIDTH-1:0] push_value, head_value;
	logic [JOB_W-1:0]       head_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_KEEP_BUILTIN: cfg_q.keep_builtin <= cfg_data;
				CFG_ESCAPE_AMP:   cfg_q.escape_amp   <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	ncr_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_value (push_value)
	);

	ncr_cmd_fifo #(
		.WIDTH(JOB_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   ({push_cmd, push_value}),
		.pop       (pop),
		.full      (fifo_full),
		.head_valid(head_valid),
		.rd_data   (head_job)
	);

	assign {head_cmd, head_value} = head_job;

	ncr_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.head_value(head_value),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

>>> rtl/core/ncr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncr_front
// Scanner: tracks reference state, accumulates the value and issues one
// expansion job for every input beat that produces output.
// ----------------------------------------------------------------------------
module ncr_front import ncr_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             text_byte,
	input  logic                   end_of_text,
	input  logic                   fifo_full,
	output logic                   push,
	output cmd_t                   push_cmd,
	output logic [VALUE_WIDTH-1:0] push_value
);

	localparam int EXT_W = VALUE_WIDTH + 4;
	localparam logic [EXT_W-1:0] LIMIT = {4'b0, {VALUE_WIDTH{1'b1}}};

	scan_mode_t             mode_q, mode_d;
	logic [VALUE_WIDTH-1:0] val_q, val_d;
	logic                   accept;
	logic                   is_dec, is_hex, is_x, is_semi, is_amp;
	logic [3:0]             hex_nib;
	logic [VALUE_WIDTH-1:0] ev;
	logic [EXT_W-1:0]       ev_ext, dec_sum, hex_sum;
	logic [VALUE_WIDTH-1:0] dec_acc, hex_acc;
	scan_mode_t             plain_mode;
	logic                   emit_amp, emit_ref, emit_plain;
	logic [31:0]            rv32;
	logic                   is_builtin;

	assign in_stall = fifo_full;
	assign accept   = in_valid && !fifo_full;

	assign is_dec  = (text_byte >= 8'h30) && (text_byte <= 8'h39);
	assign is_hex  = is_dec || ((text_byte >= 8'h61) && (text_byte <= 8'h66)) ||
	                 ((text_byte >= 8'h41) && (text_byte <= 8'h46));
	assign is_x    = (text_byte == CH_X);
	assign is_semi = (text_byte == CH_SEMI);
	assign is_amp  = (text_byte == CH_AMP);
	assign hex_nib = is_dec ? text_byte[3:0] : text_byte[3:0] + 4'd9;

	// value still zero right after "&#"
	assign ev      = (mode_q == MODE_HASH) ? '0 : val_q;
	assign ev_ext  = EXT_W'(ev);
	assign dec_sum = (ev_ext << 3) + (ev_ext << 1) + EXT_W'(text_byte[3:0]);
	assign hex_sum = (ev_ext << 4) + EXT_W'(hex_nib);
	assign dec_acc = (dec_sum > LIMIT) ? '1 : dec_sum[VALUE_WIDTH-1:0];
	assign hex_acc = (hex_sum > LIMIT) ? '1 : hex_sum[VALUE_WIDTH-1:0];

	assign plain_mode = is_amp ? MODE_AMP : MODE_IDLE;

	// next state
	always_comb begin
		mode_d = mode_q;
		val_d  = val_q;
		if (end_of_text) begin
			mode_d = MODE_IDLE;
			val_d  = '0;
		end else begin
			unique case (mode_q)
				MODE_AMP: begin
					mode_d = (text_byte == CH_HASH) ? MODE_HASH : plain_mode;
				end
				MODE_HASH: begin
					if (is_x) begin
						mode_d = MODE_HEX;
						val_d  = '0;
					end else if (is_dec) begin
						mode_d = MODE_DEC;
						val_d  = dec_acc;
					end else begin
						mode_d = plain_mode;
						val_d  = '0;
					end
				end
				MODE_DEC: begin
					if (is_dec) begin
						val_d = dec_acc;
					end else begin
						mode_d = plain_mode;
						val_d  = '0;
					end
				end
				MODE_HEX: begin
					if (is_hex) begin
						val_d = hex_acc;
					end else begin
						mode_d = plain_mode;
						val_d  = '0;
					end
				end
				default: begin
					mode_d = plain_mode;
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		emit_amp   = 1'b0;
		emit_ref   = 1'b0;
		emit_plain = 1'b0;
		if (end_of_text) begin
			unique case (mode_q)
				MODE_AMP:                      emit_amp = 1'b1;
				MODE_HASH, MODE_DEC, MODE_HEX: emit_ref = 1'b1;
				default:                       emit_ref = 1'b0;
			endcase
		end else begin
			unique case (mode_q)
				MODE_AMP: begin
					emit_amp   = (text_byte != CH_HASH);
					emit_plain = (text_byte != CH_HASH) && !is_amp;
				end
				MODE_HASH: begin
					emit_ref   = !is_x && !is_dec;
					emit_plain = !is_x && !is_dec && !is_semi && !is_amp;
				end
				MODE_DEC: begin
					emit_ref   = !is_dec;
					emit_plain = !is_dec && !is_semi && !is_amp;
				end
				MODE_HEX: begin
					emit_ref   = !is_hex;
					emit_plain = !is_hex && !is_semi && !is_amp;
				end
				default: begin
					emit_plain = !is_amp;
				end
			endcase
		end
	end

	assign rv32       = 32'(ev);
	assign is_builtin = cfg.keep_builtin &&
	                    (rv32 == 32'd34 || rv32 == 32'd38 || rv32 == 32'd60 || rv32 == 32'd62);

	always_comb begin
		push_cmd            = '0;
		push_cmd.ref_form   = REF_NONE;
		push_cmd.amp_len    = emit_amp ? (cfg.escape_amp ? AMP_LEN_ESC : AMP_LEN_PLAIN) : 3'd0;
		push_cmd.has_plain  = emit_plain;
		push_cmd.plain_byte = text_byte;
		if (emit_ref) begin
			if (is_builtin) begin
				push_cmd.ref_form = (mode_q == MODE_HEX) ? REF_KEEP_HEX : REF_KEEP_DEC;
				push_cmd.ref_len  = (mode_q == MODE_HEX) ? KEEP_HEX_LEN : KEEP_DEC_LEN;
			end else begin
				push_cmd.ref_form = REF_UTF8;
				priority if (rv32 <= 32'h7F)      push_cmd.ref_len = 3'd1;
				else if (rv32 <= 32'h7FF)         push_cmd.ref_len = 3'd2;
				else if (rv32 <= 32'hFFFF)        push_cmd.ref_len = 3'd3;
				else if (rv32 <= 32'h1FFFFF)      push_cmd.ref_len = 3'd4;
				else if (rv32 <= 32'h3FFFFFF)     push_cmd.ref_len = 3'd5;
				else                              push_cmd.ref_len = 3'd6;
			end
		end
	end

	assign push_value = ev;
	assign push       = accept && (emit_amp || emit_ref || emit_plain);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			val_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			val_q  <= val_d;
		end
	end

endmodule

>>> rtl/core/ncr_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncr_cmd_fifo
// Short job queue between scanner and expander.
// ----------------------------------------------------------------------------
module ncr_cmd_fifo import ncr_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = $clog2(CMD_DEPTH);
	localparam int CNT_W = $clog2(CMD_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(CMD_DEPTH));
	assign head_valid = (count_q != '0);
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/ncr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncr_back
// Expander: walks the head job one output byte per cycle, unless the output
// stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module ncr_back import ncr_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  cmd_t                   head_cmd,
	input  logic [VALUE_WIDTH-1:0] head_value,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             out_byte,
	output logic                   last
);

	logic [2:0]  pos_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;
	logic        load, final_c;
	logic [3:0]  total, amp_end;
	logic [2:0]  ref_idx, shift_idx;
	logic [39:0] v_ext;
	logic [7:0]  slice, lead, amp_char, ref_char, byte_c;
	logic [15:0] keep_dec, keep_hex;

	assign total   = 4'(head_cmd.amp_len) + 4'(head_cmd.ref_len) + 4'(head_cmd.has_plain);
	assign amp_end = 4'(head_cmd.amp_len);
	assign final_c = (4'(pos_q) + 4'd1 == total);
	assign load    = head_valid && (!out_valid_q || !out_stall);
	assign pop     = load && final_c;

	assign ref_idx   = pos_q - head_cmd.amp_len;
	assign shift_idx = head_cmd.ref_len - 3'd1 - ref_idx;
	assign v_ext     = 40'(head_value);

	always_comb begin
		unique case (shift_idx)
			3'd0:    slice = v_ext[7:0];
			3'd1:    slice = v_ext[13:6];
			3'd2:    slice = v_ext[19:12];
			3'd3:    slice = v_ext[25:18];
			3'd4:    slice = v_ext[31:24];
			3'd5:    slice = v_ext[37:30];
			default: slice = 8'h00;
		endcase
	end

	always_comb begin
		unique case (head_cmd.ref_len)
			3'd1:    lead = slice;
			3'd2:    lead = 8'hC0 | slice;
			3'd3:    lead = 8'hE0 | slice;
			3'd4:    lead = 8'hF0 | slice;
			3'd5:    lead = 8'hF8 | slice;
			default: lead = 8'hFC | slice;
		endcase
	end

	// digit pairs for the four kept references
	always_comb begin
		unique case (head_value[7:0])
			8'd34:   begin keep_dec = 16'h3334; keep_hex = 16'h3232; end
			8'd38:   begin keep_dec = 16'h3338; keep_hex = 16'h3236; end
			8'd60:   begin keep_dec = 16'h3630; keep_hex = 16'h3363; end
			8'd62:   begin keep_dec = 16'h3632; keep_hex = 16'h3365; end
			default: begin keep_dec = 16'h0000; keep_hex = 16'h0000; end
		endcase
	end

	always_comb begin
		unique case (pos_q)
			3'd0:    amp_char = 8'h26;
			3'd1:    amp_char = 8'h61;
			3'd2:    amp_char = 8'h6D;
			3'd3:    amp_char = 8'h70;
			default: amp_char = 8'h3B;
		endcase
	end

	always_comb begin
		unique case (head_cmd.ref_form)
			REF_KEEP_DEC: begin
				unique case (ref_idx)
					3'd0:    ref_char = 8'h26;
					3'd1:    ref_char = 8'h23;
					3'd2:    ref_char = keep_dec[15:8];
					3'd3:    ref_char = keep_dec[7:0];
					default: ref_char = 8'h3B;
				endcase
			end
			REF_KEEP_HEX: begin
				unique case (ref_idx)
					3'd0:    ref_char = 8'h26;
					3'd1:    ref_char = 8'h23;
					3'd2:    ref_char = 8'h78;
					3'd3:    ref_char = keep_hex[15:8];
					3'd4:    ref_char = keep_hex[7:0];
					default: ref_char = 8'h3B;
				endcase
			end
			REF_UTF8: begin
				ref_char = (ref_idx == 3'd0) ? lead : (8'h80 | {2'b00, slice[5:0]});
			end
			default: begin
				ref_char = 8'h00;
			end
		endcase
	end

	always_comb begin
		priority if (4'(pos_q) < amp_end)                             byte_c = amp_char;
		else if (4'(pos_q) < amp_end + 4'(head_cmd.ref_len))          byte_c = ref_char;
		else                                                          byte_c = head_cmd.plain_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			pos_q       <= final_c ? 3'd0 : pos_q + 3'd1;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= byte_c;
			last_q     <= final_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

>>> rtl/core/ncr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncr_checker
// Port-level checks for the character reference decoder.
// ----------------------------------------------------------------------------
module ncr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last
);

	// a held output beat keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("output beat changed while stalled");

	// output is empty at the first edge after reset is released
	a_reset_quiet: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

	// a full job queue always leaves a valid output beat next cycle
	a_full_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> out_valid)
		else $error("input stalled without pending output");

endmodule

bind numeric_char_reference_to_utf8_core ncr_checker u_ncr_checker (.*);
